// ===== src/fbfl_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fbfl_pkg
// Shared types and constants of the fixed block free list allocator: pool
// sizing, request and status codes, register indexes and the stack commands.
// ============================================================================
package fbfl_pkg;

    // Pool sizing.
    localparam int POOL_DEPTH = 256;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int ADDR_W     = 32;
    localparam int SHIFT_W    = 5;
    localparam int DATA_W     = 32;
    localparam int PADDR_W    = 4;

    // Legal range of the block size exponent.
    localparam logic [SHIFT_W-1:0] SHIFT_MIN = SHIFT_W'(2);
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = SHIFT_W'(16);

    // Register reset values.
    localparam logic [ADDR_W-1:0]  BASE_RST  = '0;
    localparam logic [SHIFT_W-1:0] SHIFT_RST = SHIFT_W'(6);
    localparam logic [CNT_W-1:0]   COUNT_RST = CNT_W'(POOL_DEPTH);

    // Request codes.
    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_REJECTED  = 2'd2,
        ST_NULL_FREE = 2'd3
    } status_t;

    // Register indexes, taken from paddr word bits.
    typedef enum logic [1:0] {
        REG_BASE  = 2'd0,
        REG_SHIFT = 2'd1,
        REG_COUNT = 2'd2,
        REG_SPARE = 2'd3
    } reg_idx_t;

    // Command broadcast along the row of stack cells.
    typedef enum logic [1:0] {
        CMD_HOLD = 2'd0,
        CMD_PUSH = 2'd1,
        CMD_POP  = 2'd2,
        CMD_LOAD = 2'd3
    } stack_cmd_t;

    // Effective configuration handed from the register block to the datapath.
    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [SHIFT_W-1:0] shift;
        logic [CNT_W-1:0]   count;
        logic [ADDR_W:0]    pool_end;
        logic               rebuild;
    } cfg_t;

endpackage

// ===== src/fbfl_req_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fbfl_req_if
// Request channel: valid/ready handshake carrying a request code and address.
// ============================================================================
interface fbfl_req_if
    import fbfl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output req_type, output address, input ready);
    modport sink   (input valid, input req_type, input address, output ready);
endinterface

// ===== src/fbfl_rsp_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fbfl_rsp_if
// Response channel: valid/ready handshake carrying the result of one request.
// ============================================================================
interface fbfl_rsp_if
    import fbfl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] block_addr;
    logic [1:0]        status;
    logic              in_pool;

    modport source (output valid, output block_addr, output status, output in_pool,
                    input ready);
    modport sink   (input valid, input block_addr, input status, input in_pool,
                    output ready);
endinterface

// ===== src/fbfl_cfg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fbfl_cfg
// APB register block. Holds the raw registers, clamps them to their legal
// ranges, precomputes the pool end address and requests a stack rebuild
// after reset and after every write to the base, shift or count register.
// ============================================================================
module fbfl_cfg
    import fbfl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [ADDR_W-1:0]  base_reg,     base_next;
    logic [SHIFT_W-1:0] shift_reg,    shift_next;
    logic [CNT_W-1:0]   count_reg,    count_next;
    logic [ADDR_W:0]    pool_end_reg, pool_end_next;
    logic               rebuild_reg,  rebuild_next;

    logic               wr_en;
    reg_idx_t           wr_idx;
    logic [SHIFT_W-1:0] eff_shift;
    logic [CNT_W-1:0]   eff_count;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    // Register writes; a write to the spare slot changes nothing.
    always_comb
    begin
        base_next    = base_reg;
        shift_next   = shift_reg;
        count_next   = count_reg;
        rebuild_next = 1'b0;
        if (wr_en)
        begin
            unique case (wr_idx)
                REG_BASE:
                begin
                    base_next    = pwdata;
                    rebuild_next = 1'b1;
                end
                REG_SHIFT:
                begin
                    shift_next   = pwdata[SHIFT_W-1:0];
                    rebuild_next = 1'b1;
                end
                REG_COUNT:
                begin
                    count_next   = pwdata[CNT_W-1:0];
                    rebuild_next = 1'b1;
                end
                REG_SPARE:
                begin
                    rebuild_next = 1'b0;
                end
            endcase
        end
    end

    // Clamp the raw values to their legal ranges.
    always_comb
    begin
        priority if (shift_reg < SHIFT_MIN)
            eff_shift = SHIFT_MIN;
        else if (shift_reg > SHIFT_MAX)
            eff_shift = SHIFT_MAX;
        else
            eff_shift = shift_reg;

        priority if (count_reg == '0)
            eff_count = CNT_W'(1);
        else if (count_reg > CNT_W'(POOL_DEPTH))
            eff_count = CNT_W'(POOL_DEPTH);
        else
            eff_count = count_reg;
    end

    // End of the pool without wrap; settles during the rebuild cycle.
    assign pool_end_next = {1'b0, base_reg} + ((ADDR_W+1)'(eff_count) << eff_shift);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= BASE_RST;
            shift_reg    <= SHIFT_RST;
            count_reg    <= COUNT_RST;
            pool_end_reg <= {1'b0, BASE_RST} + ((ADDR_W+1)'(COUNT_RST) << SHIFT_RST);
            rebuild_reg  <= 1'b1;
        end
        else
        begin
            base_reg     <= base_next;
            shift_reg    <= shift_next;
            count_reg    <= count_next;
            pool_end_reg <= pool_end_next;
            rebuild_reg  <= rebuild_next;
        end
    end

    // Read back of the raw registers.
    always_comb
    begin
        unique case (wr_idx)
            REG_BASE:  prdata = base_reg;
            REG_SHIFT: prdata = DATA_W'(shift_reg);
            REG_COUNT: prdata = DATA_W'(count_reg);
            REG_SPARE: prdata = '0;
        endcase
    end

    assign cfg.base     = base_reg;
    assign cfg.shift    = eff_shift;
    assign cfg.count    = eff_count;
    assign cfg.pool_end = pool_end_reg;
    assign cfg.rebuild  = rebuild_reg;

endmodule

// ===== src/fbfl_cell.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fbfl_cell
// One entry of the shifting free stack. On a push it takes the entry above
// it, on a pop the entry below it, and on a load its place in a full stack.
// ============================================================================
module fbfl_cell
    import fbfl_pkg::*;
(
    input  logic             clk,
    input  stack_cmd_t       cmd,
    input  logic [IDX_W-1:0] cell_idx,
    input  logic [CNT_W-1:0] count,
    input  logic [IDX_W-1:0] from_prev,
    input  logic [IDX_W-1:0] from_next,
    output logic [IDX_W-1:0] value
);

    logic [IDX_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0] load_val;

    // A full stack holds count-1 at the top, counting down toward the bottom.
    assign load_val = count - CNT_W'(1) - CNT_W'(cell_idx);

    always_comb
    begin
        unique case (cmd)
            CMD_HOLD: value_next = value_reg;
            CMD_PUSH: value_next = from_prev;
            CMD_POP:  value_next = from_next;
            CMD_LOAD: value_next = load_val[IDX_W-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== src/fbfl_stack.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fbfl_stack
// Row of stack cells with the top of stack in cell zero. Every cell moves
// together under one broadcast command.
// ============================================================================
module fbfl_stack
    import fbfl_pkg::*;
(
    input  logic             clk,
    input  stack_cmd_t       cmd,
    input  logic [CNT_W-1:0] count,
    input  logic [IDX_W-1:0] push_data,
    output logic [IDX_W-1:0] top
);

    logic [IDX_W-1:0] vals [POOL_DEPTH];

    for (genvar j = 0; j < POOL_DEPTH; j++)
    begin : g_cell
        logic [IDX_W-1:0] prev_val;
        logic [IDX_W-1:0] next_val;

        // Cell zero is fed by the pushed index; the bottom cell keeps itself.
        if (j == 0)
        begin : g_top
            assign prev_val = push_data;
        end
        else
        begin : g_mid
            assign prev_val = vals[j-1];
        end

        if (j == POOL_DEPTH - 1)
        begin : g_bottom
            assign next_val = vals[j];
        end
        else
        begin : g_upper
            assign next_val = vals[j+1];
        end

        fbfl_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .cell_idx  (IDX_W'(j)),
            .count     (count),
            .from_prev (prev_val),
            .from_next (next_val),
            .value     (vals[j])
        );
    end

    assign top = vals[0];

endmodule

// ===== src/fixed_block_free_list_allocator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fixed_block_free_list_allocator
// Pool of equal blocks handed out and taken back through a LIFO free stack.
// ============================================================================
// Usage:
//   Requests arrive on req (allocate, free or contains query) and each gives
//   exactly one beat on rsp. The free stack is a row of cells that shift as
//   one, so the top index is always in cell zero next to the count register.
//   A response beat is registered, valid in the cycle after its request is
//   accepted; one request is taken every cycle unless rsp stalls or a
//   rebuild runs; the limit is the single top-of-stack cell and count update per cycle.
//   The response sits in an output register; while rsp is stalled with a beat
//   pending and not taken, req.ready stays low, and a new request is taken in
//   the same cycle that the pending beat leaves.
//   After reset, and in the cycle after a write to base, shift or count, the
//   stack is reloaded with every block index; req.ready is low in that cycle.
//   Registers are written over the APB port: base address, block size exponent
//   and block count; the user writes them only while the block is idle, which the block itself does not enforce.
// ============================================================================
module fixed_block_free_list_allocator
    import fbfl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    fbfl_req_if.sink           req,
    fbfl_rsp_if.source         rsp
);

    cfg_t             cfg;
    stack_cmd_t       cmd;
    logic [IDX_W-1:0] top;
    logic [IDX_W-1:0] push_idx;

    logic [CNT_W-1:0]  free_count_reg, free_count_next;
    logic              rsp_valid_reg,  rsp_valid_next;
    logic [ADDR_W-1:0] block_addr_reg, block_addr_next;
    status_t           status_reg,     status_next;
    logic              in_pool_reg,    in_pool_next;

    logic              accept;
    req_t              req_code;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] shifted_off;
    logic [ADDR_W-1:0] align_mask;
    logic              in_range;
    logic              aligned;
    logic              stack_full;
    logic              pop_ok;
    logic              push_ok;

    fbfl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fbfl_stack u_stack (
        .clk       (clk),
        .cmd       (cmd),
        .count     (cfg.count),
        .push_data (push_idx),
        .top       (top)
    );

    // Handshake: hold off during a rebuild or while a result is stuck.
    assign req.ready = !cfg.rebuild && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign req_code  = req_t'(req.req_type);

    // Address checks against the pool.
    assign offset      = req.address - cfg.base;
    assign align_mask  = (ADDR_W'(1) << cfg.shift) - ADDR_W'(1);
    assign shifted_off = offset >> cfg.shift;
    assign push_idx    = shifted_off[IDX_W-1:0];
    assign in_range    = (req.address >= cfg.base) && ({1'b0, req.address} < cfg.pool_end);
    assign aligned     = (offset & align_mask) == '0;
    assign stack_full  = free_count_reg >= cfg.count;

    assign pop_ok  = accept && (req_code == REQ_ALLOC) && (free_count_reg != '0);
    assign push_ok = accept && (req_code == REQ_FREE) && (req.address != '0)
                     && in_range && aligned && !stack_full;

    // Result of the request being accepted.
    always_comb
    begin
        block_addr_next = '0;
        status_next     = ST_OK;
        in_pool_next    = 1'b0;
        unique case (req_code)
            REQ_ALLOC:
            begin
                if (free_count_reg == '0)
                    status_next = ST_EMPTY;
                else
                    block_addr_next = cfg.base + (ADDR_W'(top) << cfg.shift);
            end
            REQ_FREE:
            begin
                priority if (req.address == '0)
                    status_next = ST_NULL_FREE;
                else if (!in_range || !aligned || stack_full)
                    status_next = ST_REJECTED;
                else
                    status_next = ST_OK;
            end
            REQ_QUERY:
            begin
                in_pool_next = in_range;
            end
            REQ_NONE:
            begin
                in_pool_next = 1'b0;
            end
        endcase
    end

    // Stack command and free count.
    always_comb
    begin
        priority if (cfg.rebuild)
        begin
            cmd             = CMD_LOAD;
            free_count_next = cfg.count;
        end
        else if (pop_ok)
        begin
            cmd             = CMD_POP;
            free_count_next = free_count_reg - CNT_W'(1);
        end
        else if (push_ok)
        begin
            cmd             = CMD_PUSH;
            free_count_next = free_count_reg + CNT_W'(1);
        end
        else
        begin
            cmd             = CMD_HOLD;
            free_count_next = free_count_reg;
        end
    end

    // Output register valid.
    always_comb
    begin
        priority if (accept)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg <= COUNT_RST;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            free_count_reg <= free_count_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Response payload, loaded only on an accepted request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            block_addr_reg <= block_addr_next;
            status_reg     <= status_next;
            in_pool_reg    <= in_pool_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.block_addr = block_addr_reg;
    assign rsp.status     = status_reg;
    assign rsp.in_pool    = in_pool_reg;

    // The free count never exceeds the pool size outside a rebuild.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg.rebuild |-> free_count_reg <= cfg.count)
        else $error("free count above block count");

    // A rebuild leaves the stack full.
    a_rebuild_full: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.rebuild |=> free_count_reg == $past(cfg.count))
        else $error("rebuild did not refill the free count");

    // A successful allocate takes exactly one block.
    a_alloc_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_code == REQ_ALLOC && free_count_reg != '0)
        |=> free_count_reg == $past(free_count_reg) - CNT_W'(1))
        else $error("allocate did not pop one entry");

    // An empty-pool response never carries an address.
    a_empty_null: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg == ST_EMPTY) |-> block_addr_reg == '0)
        else $error("empty response with an address");

endmodule

// ===== tb/sv/fbfl_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fbfl_checker
// Watches the register port and both beat channels of the allocator. It keeps
// its own copy of the registers and of the LIFO free stack, works out the
// response of every accepted request and compares each response beat, field
// by field, with the oldest response still due.
// ============================================================================
module fbfl_checker
    import fbfl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    input  logic               pready,
    fbfl_req_if                req,
    fbfl_rsp_if                rsp,
    output int                 fail_count,
    output int                 outstanding
);

    typedef struct packed {
        logic [ADDR_W-1:0] block_addr;
        status_t           status;
        logic              in_pool;
    } pool_rsp_t;

    // Register copies and the predicted free stack.
    logic [ADDR_W-1:0]  base_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   free_idx [POOL_DEPTH];
    logic [CNT_W-1:0]   free_total;
    pool_rsp_t          due_rsp_q [$];

    // Block size exponent as the pool uses it, clamped to the legal range.
    function automatic logic [SHIFT_W-1:0] block_shift();
        if (shift_reg < SHIFT_MIN) return SHIFT_MIN;
        if (shift_reg > SHIFT_MAX) return SHIFT_MAX;
        return shift_reg;
    endfunction

    // Number of blocks as the pool uses it, clamped to 1..POOL_DEPTH.
    function automatic logic [CNT_W-1:0] pool_blocks();
        if (count_reg == '0) return CNT_W'(1);
        if (count_reg > CNT_W'(POOL_DEPTH)) return CNT_W'(POOL_DEPTH);
        return count_reg;
    endfunction

    // The pool end is computed two bits wider, so a pool that runs past the
    // top of memory never wraps around to low addresses.
    function automatic logic pool_hit(logic [ADDR_W-1:0] a);
        logic [ADDR_W+1:0] lo;
        logic [ADDR_W+1:0] hi;
        logic [ADDR_W+1:0] wide_count;
        lo         = {2'b00, base_reg};
        wide_count = '0;
        wide_count[CNT_W-1:0] = pool_blocks();
        hi         = lo + (wide_count << block_shift());
        return ({2'b00, a} >= lo) && ({2'b00, a} < hi);
    endfunction

    // Every index back on the stack, highest on top.
    function automatic void reload_stack();
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            free_idx[i] = IDX_W'(i);
        end
        free_total = pool_blocks();
    endfunction

    // Applies one request to the predicted pool and returns its response.
    function automatic pool_rsp_t serve_request(req_t kind, logic [ADDR_W-1:0] a);
        pool_rsp_t          r;
        logic [ADDR_W-1:0]  off;
        logic [ADDR_W-1:0]  mask;
        logic [SHIFT_W-1:0] sh;
        logic [IDX_W-1:0]   idx;
        sh           = block_shift();
        r.block_addr = '0;
        r.status     = ST_OK;
        r.in_pool    = 1'b0;
        case (kind)
            REQ_ALLOC:
            begin
                if (free_total == '0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    free_total   = free_total - CNT_W'(1);
                    idx          = free_idx[free_total[IDX_W-1:0]];
                    r.block_addr = base_reg + (ADDR_W'(idx) << sh);
                end
            end
            REQ_FREE:
            begin
                if (a == '0)
                begin
                    r.status = ST_NULL_FREE;
                end
                else
                begin
                    off  = a - base_reg;
                    mask = (ADDR_W'(1) << sh) - ADDR_W'(1);
                    if (!pool_hit(a) || (off & mask) != '0 || free_total >= pool_blocks())
                    begin
                        r.status = ST_REJECTED;
                    end
                    else
                    begin
                        free_idx[free_total[IDX_W-1:0]] = IDX_W'(off >> sh);
                        free_total = free_total + CNT_W'(1);
                    end
                end
            end
            REQ_QUERY:
            begin
                r.in_pool = pool_hit(a);
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Response beats are checked before the request beat of the same edge is
    // predicted; a register write only lands while nothing is in flight.
    always @(posedge clk)
    begin
        pool_rsp_t want;
        if (!rst_n)
        begin
            base_reg   = BASE_RST;
            shift_reg  = SHIFT_RST;
            count_reg  = COUNT_RST;
            reload_stack();
            due_rsp_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (due_rsp_q.size() == 0)
                begin
                    $error("response beat with no request outstanding: block_addr %h",
                           rsp.block_addr);
                    fail_count++;
                end
                else
                begin
                    want = due_rsp_q.pop_front();
                    if (rsp.block_addr !== want.block_addr)
                    begin
                        $error("block_addr mismatch: expected %h, got %h",
                               want.block_addr, rsp.block_addr);
                        fail_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.in_pool !== want.in_pool)
                    begin
                        $error("in_pool mismatch: expected %0d, got %0d",
                               want.in_pool, rsp.in_pool);
                        fail_count++;
                    end
                end
            end

            // Any write to a real register rebuilds the stack.
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[PADDR_W-1:2]))
                    REG_BASE:  base_reg  = pwdata[ADDR_W-1:0];
                    REG_SHIFT: shift_reg = pwdata[SHIFT_W-1:0];
                    REG_COUNT: count_reg = pwdata[CNT_W-1:0];
                    default:
                    begin
                    end
                endcase
                if (reg_idx_t'(paddr[PADDR_W-1:2]) != REG_SPARE)
                begin
                    reload_stack();
                end
            end

            if (req.valid && req.ready)
            begin
                due_rsp_q.push_back(serve_request(req_t'(req.req_type), req.address));
            end
        end
        outstanding <= due_rsp_q.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Stimulus and verdict for the fixed block free list allocator. A directed
// run covers the pool edges, every request kind, empty and full stacks, null
// and rejected frees and a pool that runs past the top of memory; random
// phases then change the pool setup and the idle pattern of both channels.
// ============================================================================
module tb;
    import fbfl_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    int                 fail_count;
    int                 outstanding;

    // Idle pattern of the current phase, in percent of cycles.
    int                 send_idle_pct;
    int                 stall_pct;

    // Effective pool setup, used to aim frees and queries at the pool.
    logic [ADDR_W-1:0]  pool_base;
    logic [SHIFT_W-1:0] pool_shift;
    logic [CNT_W-1:0]   pool_blocks;

    fbfl_req_if req_if ();
    fbfl_rsp_if rsp_if ();

    fixed_block_free_list_allocator DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_if),
        .rsp     (rsp_if)
    );

    fbfl_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .req         (req_if),
        .rsp         (rsp_if),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Response side: stalls at random with the rate of the current phase.
    initial
    begin
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // One request beat, after a random number of idle cycles.
    task automatic send_req(req_t kind, logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= kind;
        req_if.address  <= addr;
        do @(posedge clk); while (!req_if.ready);
    endtask

    // Every request has one response, so the block is idle once all are in.
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Writes all three registers and records the setup the pool will use.
    task automatic set_pool(logic [ADDR_W-1:0] base, logic [SHIFT_W-1:0] shift_raw,
                            logic [CNT_W-1:0] count_raw);
        wait_idle();
        write_reg(REG_BASE, base);
        write_reg(REG_SHIFT, DATA_W'(shift_raw));
        write_reg(REG_COUNT, DATA_W'(count_raw));
        pool_base   = base;
        pool_shift  = (shift_raw < SHIFT_MIN) ? SHIFT_MIN :
                      (shift_raw > SHIFT_MAX) ? SHIFT_MAX : shift_raw;
        pool_blocks = (count_raw == '0) ? CNT_W'(1) :
                      (count_raw > CNT_W'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH) : count_raw;
    endtask

    // Mostly allocates and frees of real blocks, with some null, misaligned
    // and out-of-pool frees, queries around the pool edges and unknown codes.
    task automatic random_req();
        int                pick;
        int                slot;
        logic [ADDR_W-1:0] blk_bytes;
        logic [ADDR_W-1:0] span;
        logic [ADDR_W-1:0] slot_addr;
        logic [ADDR_W-1:0] addr;
        pick      = $urandom_range(99);
        slot      = $urandom_range(int'(pool_blocks) - 1);
        blk_bytes = ADDR_W'(1) << pool_shift;
        span      = ADDR_W'(pool_blocks) << pool_shift;
        slot_addr = pool_base + (ADDR_W'(slot) << pool_shift);
        if (pick < 40)
        begin
            send_req(REQ_ALLOC, $urandom);
        end
        else if (pick < 72)
        begin
            send_req(REQ_FREE, slot_addr);
        end
        else if (pick < 76)
        begin
            send_req(REQ_FREE, '0);
        end
        else if (pick < 86)
        begin
            case ($urandom_range(3))
                0:       addr = slot_addr + $urandom_range(1, blk_bytes - 1);
                1:       addr = pool_base - ADDR_W'(1);
                2:       addr = pool_base + span;
                default: addr = $urandom;
            endcase
            send_req(REQ_FREE, addr);
        end
        else if (pick < 97)
        begin
            case ($urandom_range(4))
                0:       addr = slot_addr + $urandom_range(blk_bytes - 1);
                1:       addr = pool_base - ADDR_W'(1);
                2:       addr = pool_base + span - ADDR_W'(1);
                3:       addr = pool_base + span;
                default: addr = $urandom;
            endcase
            send_req(REQ_QUERY, addr);
        end
        else
        begin
            send_req(REQ_NONE, $urandom);
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        req_if.valid    <= 1'b0;
        req_if.req_type <= REQ_ALLOC;
        req_if.address  <= '0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        pool_base       = BASE_RST;
        pool_shift      = SHIFT_RST;
        pool_blocks     = COUNT_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setup: 256 blocks of 64 bytes at address zero, stack full.
        send_req(REQ_FREE,  32'h0000_0040);
        send_req(REQ_ALLOC, 32'h0000_0000);
        send_req(REQ_FREE,  32'h0000_0000);
        send_req(REQ_QUERY, 32'h0000_0000);
        send_req(REQ_QUERY, 32'h0000_3FFF);
        send_req(REQ_QUERY, 32'h0000_4000);
        send_req(REQ_QUERY, 32'hFFFF_FFFF);
        send_req(REQ_FREE,  32'h0000_3FC1);
        send_req(REQ_FREE,  32'h0000_4000);
        send_req(REQ_FREE,  32'h0000_3FC0);
        send_req(REQ_NONE,  32'hFFFF_FFFF);

        // Two 64 KiB blocks, the second past the top of memory; shift too big.
        set_pool(32'hFFFF_0000, SHIFT_W'(17), CNT_W'(2));
        send_req(REQ_ALLOC, 32'hFFFF_FFFF);
        send_req(REQ_FREE,  32'h0000_0000);
        send_req(REQ_ALLOC, 32'h0000_0000);
        send_req(REQ_ALLOC, 32'h0000_0000);
        send_req(REQ_QUERY, 32'hFFFF_FFFF);
        send_req(REQ_FREE,  32'hFFFF_0000);
        send_req(REQ_FREE,  32'hFFFF_0000);
        send_req(REQ_FREE,  32'hFFFF_0000);

        // Shift and count below their ranges: one 4-byte block.
        set_pool(32'h0000_1000, SHIFT_W'(0), CNT_W'(0));
        send_req(REQ_QUERY, 32'h0000_0FFF);
        send_req(REQ_QUERY, 32'h0000_1003);
        send_req(REQ_ALLOC, 32'h0000_0000);
        send_req(REQ_ALLOC, 32'h0000_0000);
        send_req(REQ_FREE,  32'h0000_1004);
        send_req(REQ_FREE,  32'h0000_1000);

        // Random phases: extreme setups first, then mostly small pools.
        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase)
                0: set_pool($urandom, SHIFT_W'(2), CNT_W'(1));
                1: set_pool(32'hFFFF_FF00, SHIFT_W'(16), CNT_W'(256));
                2: set_pool($urandom, SHIFT_W'(31), CNT_W'(511));
                3: set_pool('0, SHIFT_W'(0), CNT_W'(0));
                4: set_pool(32'hFFFF_FFFF, SHIFT_W'(2), CNT_W'(3));
                default:
                    set_pool($urandom, SHIFT_W'($urandom_range(2, 16)),
                             ($urandom_range(3) == 0) ? CNT_W'($urandom_range(1, 511))
                                                      : CNT_W'($urandom_range(1, 12)));
            endcase
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 59;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 59;
                end
                default:
                begin
                    send_idle_pct = 20;
                    stall_pct     = 20;
                end
            endcase
            repeat (85) random_req();
        end

        // Drain, then leave room for any stray response beat.
        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
